// File: rtl/stlr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlr_pkg
// Shared types, constants and the CRC step of the scan telegram receiver.
// ----------------------------------------------------------------------------
package stlr_pkg;

  // Telegram framing bytes
  localparam logic [7:0] START_BYTE = 8'h02;
  localparam logic [7:0] ADDR_BYTE  = 8'h80;
  localparam logic [7:0] CMD_BYTE   = 8'hb0;

  // CRC polynomial
  localparam logic [15:0] CRC_POLY = 16'h8005;

  // Configuration space
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned MAX_DATA_W  = 14;
  localparam logic [MAX_DATA_W-1:0] MAX_DATA_RESET = 14'd802;
  localparam logic [0:0] REG_MAX_DATA = 1'b0;

  // Receive phases
  typedef enum logic [3:0] {
    PH_HUNT,
    PH_ADDR,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_CMD,
    PH_CNT_LO,
    PH_CNT_HI,
    PH_DATA,
    PH_STATUS,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_SAMPLE   = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_CRC_ERR  = 2'd2,
    KIND_REJECTED = 2'd3
  } kind_t;

  // One result request
  typedef struct packed {
    kind_t       kind;
    logic [12:0] distance;
    logic [12:0] sample_index;
    logic [12:0] sample_count;
    logic [7:0]  scan_status;
    logic        last;
  } result_t;

  // One byte of the device CRC: shift, fold in poly, mix current and previous byte
  function automatic logic [15:0] crc_step(input logic [15:0] crc,
                                           input logic [7:0]  prev,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = {crc[14:0], 1'b0};
    if (crc[15]) begin
      c = c ^ CRC_POLY;
    end
    return c ^ {prev, b};
  endfunction

endpackage

// File: rtl/stlr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlr_in_if
// Byte request channel into the receiver.
// ----------------------------------------------------------------------------
interface stlr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: rtl/stlr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlr_out_if
// Result request channel out of the receiver.
// ----------------------------------------------------------------------------
interface stlr_out_if
  import stlr_pkg::*;
  ;
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [12:0] distance;
  logic [12:0] sample_index;
  logic [12:0] sample_count;
  logic [7:0]  scan_status;
  logic        last;

  modport source (output valid, output kind, output distance, output sample_index,
                  output sample_count, output scan_status, output last, input ready);
  modport sink (input valid, input kind, input distance, input sample_index,
                input sample_count, input scan_status, input last, output ready);
endinterface

// File: rtl/stlr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlr_parser
// Telegram phase tracking, running CRC and per-byte result decode.
// ----------------------------------------------------------------------------
module stlr_parser
  import stlr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  input  logic [7:0]            rx_byte,
  input  logic [MAX_DATA_W-1:0] max_data_bytes,
  output logic                  res_valid,
  output result_t               res
);

  phase_t      phase, phase_next;
  logic [13:0] byte_position, byte_position_next;
  logic [12:0] announced_count, announced_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  previous_byte, previous_byte_next;
  logic [7:0]  held_low_byte, held_low_byte_next;
  logic [7:0]  held_status, held_status_next;
  logic [7:0]  received_crc_low, received_crc_low_next;

  logic [15:0] crc_fed;
  logic [12:0] count_full;
  logic [13:0] position_inc;
  logic        header_bad;

  assign crc_fed      = crc_step(running_crc, previous_byte, rx_byte);
  assign count_full   = {rx_byte[4:0], announced_count[7:0]};
  assign position_inc = byte_position + 14'd1;
  assign header_bad   = ({count_full, 1'b0} > max_data_bytes) ||
                        (held_low_byte != ADDR_BYTE) || (held_status != CMD_BYTE);

  // Next state for one byte
  always_comb begin
    phase_next            = phase;
    byte_position_next    = byte_position;
    announced_count_next  = announced_count;
    running_crc_next      = running_crc;
    previous_byte_next    = previous_byte;
    held_low_byte_next    = held_low_byte;
    held_status_next      = held_status;
    received_crc_low_next = received_crc_low;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == START_BYTE) begin
          running_crc_next   = crc_step(16'h0000, 8'h00, rx_byte);
          previous_byte_next = rx_byte;
          phase_next         = PH_ADDR;
        end
      end
      PH_ADDR: begin
        running_crc_next   = crc_fed;
        previous_byte_next = rx_byte;
        held_low_byte_next = rx_byte;
        phase_next         = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        running_crc_next   = crc_fed;
        previous_byte_next = rx_byte;
        phase_next         = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        running_crc_next   = crc_fed;
        previous_byte_next = rx_byte;
        phase_next         = PH_CMD;
      end
      PH_CMD: begin
        running_crc_next   = crc_fed;
        previous_byte_next = rx_byte;
        held_status_next   = rx_byte;
        phase_next         = PH_CNT_LO;
      end
      PH_CNT_LO: begin
        running_crc_next     = crc_fed;
        previous_byte_next   = rx_byte;
        announced_count_next = {5'd0, rx_byte};
        phase_next           = PH_CNT_HI;
      end
      PH_CNT_HI: begin
        running_crc_next     = crc_fed;
        previous_byte_next   = rx_byte;
        announced_count_next = count_full;
        if (header_bad) begin
          phase_next = PH_HUNT;
        end else begin
          byte_position_next = '0;
          phase_next = (count_full == 13'd0) ? PH_STATUS : PH_DATA;
        end
      end
      PH_DATA: begin
        running_crc_next   = crc_fed;
        previous_byte_next = rx_byte;
        byte_position_next = position_inc;
        if (!byte_position[0]) begin
          held_low_byte_next = rx_byte;
        end else if (position_inc >= {announced_count, 1'b0}) begin
          phase_next = PH_STATUS;
        end
      end
      PH_STATUS: begin
        running_crc_next   = crc_fed;
        previous_byte_next = rx_byte;
        held_status_next   = rx_byte;
        phase_next         = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        received_crc_low_next = rx_byte;
        phase_next            = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  // Result for one byte
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    case (phase)
      PH_CNT_HI: begin
        res_valid        = byte_valid && header_bad;
        res.kind         = KIND_REJECTED;
        res.sample_count = count_full;
        res.last         = 1'b1;
      end
      PH_DATA: begin
        res_valid          = byte_valid && byte_position[0];
        res.kind           = KIND_SAMPLE;
        res.distance       = {rx_byte[4:0], held_low_byte};
        res.sample_index   = byte_position[13:1];
        res.sample_count   = announced_count;
      end
      PH_CRC_HI: begin
        res_valid        = byte_valid;
        res.kind         = ({rx_byte, received_crc_low} == running_crc) ? KIND_GOOD
                                                                         : KIND_CRC_ERR;
        res.sample_count = announced_count;
        res.scan_status  = held_status;
        res.last         = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Advance on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      byte_position    <= '0;
      announced_count  <= '0;
      running_crc      <= '0;
      previous_byte    <= '0;
      held_low_byte    <= '0;
      held_status      <= '0;
      received_crc_low <= '0;
    end else if (byte_valid) begin
      phase            <= phase_next;
      byte_position    <= byte_position_next;
      announced_count  <= announced_count_next;
      running_crc      <= running_crc_next;
      previous_byte    <= previous_byte_next;
      held_low_byte    <= held_low_byte_next;
      held_status      <= held_status_next;
      received_crc_low <= received_crc_low_next;
    end
  end

endmodule

// File: rtl/scan_telegram_receiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_telegram_receiver_unit
// Byte-wide receiver for scanner measurement telegrams with CRC check.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                          | handshake
//  rx      | in  | rx_byte                                          | valid/ready
//  res     | out | kind, distance, sample_index, sample_count,      | valid/ready
//          |     | scan_status, last                                |
//  apb     | in  | max_data_bytes at byte address 0                 | psel/penable
//
//  One byte per cycle while rx.ready is high; each result is registered.
//  The phase, CRC and counters update in one step per byte; the result
//  register plus a one-entry skid buffer keep rx.ready a register output.
//  rx.ready drops only while the skid entry is full (res stalled).
//  Reset (rst, synchronous) returns to hunting for a start byte and sets
//  max_data_bytes to 802.
// ----------------------------------------------------------------------------
module scan_telegram_receiver_unit
  import stlr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  stlr_in_if.sink               rx,
  stlr_out_if.source            res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [MAX_DATA_W-1:0] max_data_bytes;
  logic                  reg_hit;
  logic                  byte_take;
  logic                  new_valid;
  result_t               new_res;
  logic                  out_valid;
  result_t               out_data;
  logic                  skid_valid;
  result_t               skid_data;
  logic                  out_fire;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_MAX_DATA);
  assign prdata  = reg_hit ? {{(32-MAX_DATA_W){1'b0}}, max_data_bytes} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_data_bytes <= MAX_DATA_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      max_data_bytes <= pwdata[MAX_DATA_W-1:0];
    end
  end

  // Per-byte decode
  assign rx.ready  = !skid_valid;
  assign byte_take = rx.valid && !skid_valid;

  stlr_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_take),
    .rx_byte        (rx.rx_byte),
    .max_data_bytes (max_data_bytes),
    .res_valid      (new_valid),
    .res            (new_res)
  );

  // Result register with skid entry
  assign out_fire = out_valid && res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (new_valid) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_data <= skid_data;
      end
    end else if (new_valid) begin
      if (!out_valid || out_fire) begin
        out_data <= new_res;
      end else begin
        skid_data <= new_res;
      end
    end
  end

  // Drive result channel
  assign res.valid        = out_valid;
  assign res.kind         = out_data.kind;
  assign res.distance     = out_data.distance;
  assign res.sample_index = out_data.sample_index;
  assign res.sample_count = out_data.sample_count;
  assign res.scan_status  = out_data.scan_status;
  assign res.last         = out_data.last;

endmodule

// File: rtl/stlr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlr_checker
// Port-level checks on the scan telegram receiver, bound to the top level.
// ----------------------------------------------------------------------------
module stlr_checker
  import stlr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input kind_t       out_kind,
  input logic [12:0] out_distance,
  input logic [12:0] out_sample_index,
  input logic [12:0] out_sample_count,
  input logic [7:0]  out_scan_status,
  input logic        out_last
);

  // No result right after reset
  a_reset_clear: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // A new result request follows a byte taken in the cycle before
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(in_valid && in_ready))
    else $error("result appeared without an accepted byte");

  // Sample position stays inside the announced count
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_SAMPLE) |-> (out_sample_index < out_sample_count))
    else $error("sample index beyond announced count");

  // Stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_kind) &&
    $stable(out_distance) && $stable(out_sample_index) && $stable(out_sample_count) &&
    $stable(out_scan_status) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind scan_telegram_receiver_unit stlr_checker u_stlr_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (rx.valid),
  .in_ready         (rx.ready),
  .out_valid        (res.valid),
  .out_ready        (res.ready),
  .out_kind         (res.kind),
  .out_distance     (res.distance),
  .out_sample_index (res.sample_index),
  .out_sample_count (res.sample_count),
  .out_scan_status  (res.scan_status),
  .out_last         (res.last)
);
